// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by cbrf_ctrl; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every rising clock edge, skipped while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/cbrf_pkg.sv =====
// ----------------------------------------------------------------------------
// cbrf_pkg
// Types, address map constants and decode helpers of the coprocessor bus
// register file.
// ----------------------------------------------------------------------------
package cbrf_pkg;

  localparam int GPR_COUNT = 16;

  // Request function codes
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_HALT  = 2'd2;

  // External region codes
  localparam logic [1:0] REGION_NONE = 2'd0;
  localparam logic [1:0] REGION_ROM  = 2'd1;
  localparam logic [1:0] REGION_SRAM = 2'd2;

  // Bus decode masks
  localparam logic [23:0] WIN_MASK      = 24'h40ec00;
  localparam logic [23:0] WIN_MATCH     = 24'h006c00;
  localparam logic [23:0] SCRATCH_MASK  = 24'h40e000;
  localparam logic [23:0] SCRATCH_MATCH = 24'h006000;
  localparam logic [23:0] ROM_MASK      = 24'h408000;
  localparam logic [23:0] ROM_MATCH     = 24'h008000;
  localparam logic [23:0] SRAM_MASK     = 24'hf88000;
  localparam logic [23:0] SRAM_MATCH    = 24'h700000;

  // Register window addresses
  localparam logic [15:0] W_DMA_SRC0  = 16'h7f40;
  localparam logic [15:0] W_DMA_SRC1  = 16'h7f41;
  localparam logic [15:0] W_DMA_SRC2  = 16'h7f42;
  localparam logic [15:0] W_DMA_LEN0  = 16'h7f43;
  localparam logic [15:0] W_DMA_LEN1  = 16'h7f44;
  localparam logic [15:0] W_DMA_TGT0  = 16'h7f45;
  localparam logic [15:0] W_DMA_TGT1  = 16'h7f46;
  localparam logic [15:0] W_DMA_TGT2  = 16'h7f47;
  localparam logic [15:0] W_CTRL48    = 16'h7f48;
  localparam logic [15:0] W_PRG_OFS0  = 16'h7f49;
  localparam logic [15:0] W_PRG_OFS1  = 16'h7f4a;
  localparam logic [15:0] W_PRG_OFS2  = 16'h7f4b;
  localparam logic [15:0] W_CTRL4C    = 16'h7f4c;
  localparam logic [15:0] W_PAGE0     = 16'h7f4d;
  localparam logic [15:0] W_PAGE1     = 16'h7f4e;
  localparam logic [15:0] W_PC        = 16'h7f4f;
  localparam logic [15:0] W_CTRL50    = 16'h7f50;
  localparam logic [15:0] W_CTRL51    = 16'h7f51;
  localparam logic [15:0] W_CTRL52    = 16'h7f52;
  localparam logic [15:0] W_STATUS_LO = 16'h7f53;
  localparam logic [15:0] W_STATUS_HI = 16'h7f5f;
  localparam logic [15:0] W_VEC_LO    = 16'h7f60;
  localparam logic [15:0] W_VEC_HI    = 16'h7f7f;
  localparam logic [15:0] W_GPR_A_LO  = 16'h7f80;
  localparam logic [15:0] W_GPR_A_HI  = 16'h7faf;
  localparam logic [15:0] W_GPR_B_LO  = 16'h7fc0;
  localparam logic [15:0] W_GPR_B_HI  = 16'h7fef;

  localparam logic [6:0] CTRL50_MASK   = 7'h77;
  localparam logic [7:0] STATUS_HALTED = 8'h02;
  localparam logic [7:0] STATUS_RUN    = 8'h40;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;    // write zero into the scratch RAM at the sweep counter
    logic capture;  // take the request and start its RAM access
    logic exec;     // update state and load the response register
  } cbrf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
  } cbrf_sts_t;

  function automatic logic is_window(input logic [23:0] a);
    return (a & WIN_MASK) == WIN_MATCH;
  endfunction

  function automatic logic is_scratch(input logic [23:0] a);
    return (a & SCRATCH_MASK) == SCRATCH_MATCH;
  endfunction

  function automatic logic is_rom(input logic [23:0] a);
    return (a & ROM_MASK) == ROM_MATCH;
  endfunction

  function automatic logic is_sram(input logic [23:0] a);
    return (a & SRAM_MASK) == SRAM_MATCH;
  endfunction

endpackage

// ===== rtl/cbrf_if.sv =====
// ----------------------------------------------------------------------------
// cbrf_if
// Request and response channels of the coprocessor bus register file.
// ----------------------------------------------------------------------------
interface cbrf_req_if;
  import cbrf_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [23:0] bus_address;
  logic [7:0]  write_byte;

  modport source (output valid, output func, output bus_address, output write_byte,
                  input ready);
  modport sink (input valid, input func, input bus_address, input write_byte,
                output ready);
endinterface

interface cbrf_rsp_if;
  import cbrf_pkg::*;

  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic [1:0]  external_region;
  logic [20:0] external_address;
  logic        dma_start;
  logic        core_start;
  logic [22:0] start_pc;

  modport source (output valid, output read_byte, output external_region,
                  output external_address, output dma_start, output core_start,
                  output start_pc, input ready);
  modport sink (input valid, input read_byte, input external_region,
                input external_address, input dma_start, input core_start,
                input start_pc, output ready);
endinterface

// ===== rtl/cbrf_ram.sv =====
// ----------------------------------------------------------------------------
// cbrf_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module cbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/cbrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbrf_ctrl
// Sequencer: scratch RAM clearing sweep, then one request at a time
// through capture, execute and response.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbrf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output cbrf_pkg::cbrf_cmd_t cmd,
  input  cbrf_pkg::cbrf_sts_t sts
);
  import cbrf_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_ready   = (state == S_IDLE);
  assign rsp_valid   = (state == S_RESP);
  assign cmd.clear   = (state == S_CLEAR);
  assign cmd.capture = (state == S_IDLE) && req_valid;
  assign cmd.exec    = (state == S_EXEC);

  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (state == S_CLEAR), "reset must start the clear sweep")
  `ASSERT_CLK(a_no_overlap, clk, rst, !(req_ready && rsp_valid), "request taken while response pending")
  `ASSERT_CLK(a_latency, clk, rst, (req_valid && req_ready) |=> ##1 rsp_valid, "response not ready two cycles after request")
  `ASSERT_CLK(a_back_idle, clk, rst, (rsp_valid && rsp_ready) |=> req_ready, "not idle after response taken")
endmodule

// ===== rtl/cbrf_datapath.sv =====
// ----------------------------------------------------------------------------
// cbrf_datapath
// Register window, vector table, general registers, scratch RAM and the
// address decode that forms one response per request.
// ----------------------------------------------------------------------------
module cbrf_datapath #(
  parameter int SCRATCH_BYTES = 3072
) (
  input  logic                clk,
  input  logic                rst,
  input  cbrf_pkg::cbrf_cmd_t cmd,
  output cbrf_pkg::cbrf_sts_t sts,
  input  logic [1:0]          req_func,
  input  logic [23:0]         req_addr,
  input  logic [7:0]          req_data,
  output logic [7:0]          read_byte,
  output logic [1:0]          external_region,
  output logic [20:0]         external_address,
  output logic                dma_start,
  output logic                core_start,
  output logic [22:0]         start_pc
);
  import cbrf_pkg::*;

  localparam int AW = $clog2(SCRATCH_BYTES);

  function automatic logic scratch_ok(input logic [23:0] a);
    return !is_window(a) && is_scratch(a) && ({1'b0, a[11:0]} < 13'(SCRATCH_BYTES));
  endfunction

  // Architectural state
  logic [23:0] dma_source;
  logic [15:0] dma_length;
  logic [23:0] dma_target;
  logic [23:0] program_offset;
  logic [14:0] page_number;
  logic [7:0]  pc_byte;
  logic [11:0] misc_flags;
  logic [7:0]  vector_table [32];
  logic [23:0] gpr [GPR_COUNT];
  logic        halted;

  // Captured request
  logic [1:0]  func_q;
  logic [23:0] addr_q;
  logic [7:0]  data_q;

  // Scratch RAM port
  logic [AW-1:0] clr_cnt;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // Decode of the captured request
  logic [15:0] w;
  logic        win_hit;
  logic        gpr_hit;
  logic [12:0] g_prod;
  logic [3:0]  gidx;
  logic [5:0]  g_base;
  logic [1:0]  glane;
  logic [23:0] gword;
  logic [7:0]  win_rd;
  logic        is_rd;
  logic        is_wr;

  logic [7:0]  res_rd;
  logic [1:0]  res_region;
  logic [20:0] res_eaddr;
  logic        res_dma;
  logic        res_core;
  logic [22:0] res_pc;

  // Clear sweep, then the scratch access of a newly accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign sts.clear_last = (clr_cnt == AW'(SCRATCH_BYTES - 1));

  assign ram_we    = cmd.clear || (cmd.capture && (req_func == FUNC_WRITE) && scratch_ok(req_addr));
  assign ram_addr  = cmd.clear ? clr_cnt : req_addr[AW-1:0];
  assign ram_wdata = cmd.clear ? 8'h00 : req_data;

  cbrf_ram #(
    .WIDTH (8),
    .DEPTH (SCRATCH_BYTES)
  ) u_scratch (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= req_func;
      addr_q <= req_addr;
      data_q <= req_data;
    end
  end

  assign w       = 16'h7c00 | {6'b0, addr_q[9:0]};
  assign win_hit = is_window(addr_q);
  assign is_rd   = (func_q == FUNC_READ);
  assign is_wr   = (func_q == FUNC_WRITE);

  // Byte slot in the general registers: index = offset / 3 by reciprocal
  assign gpr_hit = ((w >= W_GPR_A_LO) && (w <= W_GPR_A_HI)) ||
                   ((w >= W_GPR_B_LO) && (w <= W_GPR_B_HI));
  assign g_prod  = 13'(w[5:0]) * 13'd43;
  assign gidx    = g_prod[10:7];
  assign g_base  = {1'b0, gidx, 1'b0} + {2'b0, gidx};
  assign glane   = 2'(w[5:0] - g_base);
  assign gword   = gpr[gidx];

  always_comb begin
    win_rd = 8'h00;
    case (w)
      W_DMA_SRC0: win_rd = dma_source[7:0];
      W_DMA_SRC1: win_rd = dma_source[15:8];
      W_DMA_SRC2: win_rd = dma_source[23:16];
      W_DMA_LEN0: win_rd = dma_length[7:0];
      W_DMA_LEN1: win_rd = dma_length[15:8];
      W_DMA_TGT0: win_rd = dma_target[7:0];
      W_DMA_TGT1: win_rd = dma_target[15:8];
      W_DMA_TGT2: win_rd = dma_target[23:16];
      W_CTRL48:   win_rd = {7'b0, misc_flags[0]};
      W_PRG_OFS0: win_rd = program_offset[7:0];
      W_PRG_OFS1: win_rd = program_offset[15:8];
      W_PRG_OFS2: win_rd = program_offset[23:16];
      W_CTRL4C:   win_rd = {6'b0, misc_flags[2:1]};
      W_PAGE0:    win_rd = page_number[7:0];
      W_PAGE1:    win_rd = {1'b0, page_number[14:8]};
      W_PC:       win_rd = pc_byte;
      W_CTRL50:   win_rd = {1'b0, misc_flags[9:3]};
      W_CTRL51:   win_rd = {7'b0, misc_flags[10]};
      W_CTRL52:   win_rd = {7'b0, misc_flags[11]};
      default: begin
        if ((w >= W_STATUS_LO) && (w <= W_STATUS_HI)) begin
          win_rd = halted ? STATUS_HALTED : STATUS_RUN;
        end else if ((w >= W_VEC_LO) && (w <= W_VEC_HI)) begin
          win_rd = vector_table[w[4:0]];
        end else if (gpr_hit) begin
          case (glane)
            2'd0:    win_rd = gword[7:0];
            2'd1:    win_rd = gword[15:8];
            2'd2:    win_rd = gword[23:16];
            default: win_rd = 8'h00;
          endcase
        end
      end
    endcase
  end

  // Response of the captured request; the window takes priority over scratch
  always_comb begin
    res_rd     = 8'h00;
    res_region = REGION_NONE;
    res_eaddr  = '0;
    res_dma    = 1'b0;
    res_core   = 1'b0;
    res_pc     = '0;
    if (is_rd || is_wr) begin
      if (win_hit) begin
        if (is_rd) begin
          res_rd = win_rd;
        end else if (halted && (w == W_DMA_TGT2)) begin
          res_dma = 1'b1;
        end else if (halted && (w == W_PC)) begin
          res_core = 1'b1;
          res_pc   = {page_number, data_q};
        end
      end else if (is_scratch(addr_q)) begin
        if (is_rd && scratch_ok(addr_q)) res_rd = ram_rdata;
      end else if (is_rom(addr_q)) begin
        if (is_rd) begin
          res_region = REGION_ROM;
          res_eaddr  = {addr_q[21:16], addr_q[14:0]};
        end
      end else if (is_sram(addr_q)) begin
        res_region = REGION_SRAM;
        res_eaddr  = {3'b000, addr_q[18:16], addr_q[14:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_byte        <= res_rd;
      external_region  <= res_region;
      external_address <= res_eaddr;
      dma_start        <= res_dma;
      core_start       <= res_core;
      start_pc         <= res_pc;
    end
  end

  // Window register writes and halt tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      dma_source     <= '0;
      dma_length     <= '0;
      dma_target     <= '0;
      program_offset <= '0;
      page_number    <= '0;
      pc_byte        <= '0;
      misc_flags     <= '0;
      halted         <= 1'b1;
      for (int i = 0; i < 32; i++) vector_table[i] <= '0;
      for (int i = 0; i < GPR_COUNT; i++) gpr[i] <= '0;
    end else if (cmd.exec) begin
      if (func_q == FUNC_HALT) begin
        halted <= 1'b1;
      end else if (is_wr && win_hit) begin
        case (w)
          W_DMA_SRC0: dma_source[7:0]       <= data_q;
          W_DMA_SRC1: dma_source[15:8]      <= data_q;
          W_DMA_SRC2: dma_source[23:16]     <= data_q;
          W_DMA_LEN0: dma_length[7:0]       <= data_q;
          W_DMA_LEN1: dma_length[15:8]      <= data_q;
          W_DMA_TGT0: dma_target[7:0]       <= data_q;
          W_DMA_TGT1: dma_target[15:8]      <= data_q;
          W_DMA_TGT2: dma_target[23:16]     <= data_q;
          W_CTRL48:   misc_flags[0]         <= data_q[0];
          W_PRG_OFS0: program_offset[7:0]   <= data_q;
          W_PRG_OFS1: program_offset[15:8]  <= data_q;
          W_PRG_OFS2: program_offset[23:16] <= data_q;
          W_CTRL4C:   misc_flags[2:1]       <= data_q[1:0];
          W_PAGE0:    page_number[7:0]      <= data_q;
          W_PAGE1:    page_number[14:8]     <= data_q[6:0];
          W_PC: begin
            pc_byte <= data_q;
            halted  <= 1'b0;
          end
          W_CTRL50:   misc_flags[9:3]       <= data_q[6:0] & CTRL50_MASK;
          W_CTRL51:   misc_flags[10]        <= data_q[0];
          W_CTRL52:   misc_flags[11]        <= data_q[0];
          default: begin
            if ((w >= W_VEC_LO) && (w <= W_VEC_HI)) begin
              vector_table[w[4:0]] <= data_q;
            end else if (gpr_hit) begin
              case (glane)
                2'd0:    gpr[gidx][7:0]   <= data_q;
                2'd1:    gpr[gidx][15:8]  <= data_q;
                2'd2:    gpr[gidx][23:16] <= data_q;
                default: ;
              endcase
            end
          end
        endcase
      end
    end
  end
endmodule

// ===== rtl/coprocessor_bus_register_file.sv =====
// ----------------------------------------------------------------------------
// coprocessor_bus_register_file
// Host bus decode for the coprocessor: register window, vector table,
// general registers, scratch RAM and external ROM / save RAM windows.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one host bus request (func, bus_address, write_byte); rsp
//   returns exactly one response per request with the read byte, the
//   external region and address, and the DMA / core start pulses.
//   A request is taken at an edge where req.valid and req.ready are high.
//   Its response shows on rsp after the registered scratch RAM read and
//   the response register, and stays until rsp.ready. One request is in
//   flight at a time. req.ready is low while a response waits.
//   After reset the block sweeps the scratch RAM to zero, one byte per
//   cycle, with req.ready low; the window registers, vector table and
//   general registers reset to zero and the core reads as halted.
//   A stalled receiver holds the response and blocks new requests.
// ----------------------------------------------------------------------------
module coprocessor_bus_register_file #(
  parameter int SCRATCH_BYTES = 3072
) (
  input logic        clk,
  input logic        rst,
  cbrf_req_if.sink   req,
  cbrf_rsp_if.source rsp
);
  import cbrf_pkg::*;

  cbrf_cmd_t cmd;
  cbrf_sts_t sts;

  cbrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cbrf_datapath #(
    .SCRATCH_BYTES (SCRATCH_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req_func         (req.func),
    .req_addr         (req.bus_address),
    .req_data         (req.write_byte),
    .read_byte        (rsp.read_byte),
    .external_region  (rsp.external_region),
    .external_address (rsp.external_address),
    .dma_start        (rsp.dma_start),
    .core_start       (rsp.core_start),
    .start_pc         (rsp.start_pc)
  );
endmodule

// ===== sim/tb_coprocessor_bus_register_file.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coprocessor_bus_register_file
// Drives host bus requests into the register file and checks every response
// against a predictor that keeps its own copy of the registers, vector
// table, general registers and scratch RAM. Runs a directed pass, then
// random traffic under several idle and stall patterns and a long hold-off.
// ----------------------------------------------------------------------------
module tb_coprocessor_bus_register_file;
  import cbrf_pkg::*;

  localparam int SCRATCH_BYTES = 3072;
  localparam int HOLD_CYCLES   = 300;
  // Sweep plus ~1100 requests with worst gaps and stalls, taken several times
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [15:0] W_UNMAPPED  = 16'h7ff0;

  typedef struct packed {
    logic [1:0]  func;
    logic [23:0] addr;
    logic [7:0]  data;
  } bus_req_t;

  typedef struct packed {
    logic [7:0]  rd;
    logic [1:0]  region;
    logic [20:0] ext_addr;
    logic        dma;
    logic        core;
    logic [22:0] pc;
  } bus_rsp_t;

  logic clk;
  logic rst;

  cbrf_req_if req_bus ();
  cbrf_rsp_if rsp_bus ();

  coprocessor_bus_register_file #(
    .SCRATCH_BYTES(SCRATCH_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  // Shadow state of the block
  logic [23:0] src_reg = '0;
  logic [15:0] len_reg = '0;
  logic [23:0] tgt_reg = '0;
  logic [23:0] pofs_reg = '0;
  logic [14:0] page_reg = '0;
  logic [7:0]  pc_reg = '0;
  logic [13:0] ctl_bits = '0;
  logic [7:0]  vec_mem [32];
  logic [23:0] gpr_mem [GPR_COUNT];
  logic [7:0]  ram_mem [SCRATCH_BYTES];
  logic        core_halted = 1'b1;

  bus_req_t bus_req_q [$];
  bus_rsp_t due_rsp_q [$];

  int  sent_total = 0;
  int  taken_total = 0;
  int  mism_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_cnt = 0;
  logic hold_on = 1'b0;
  logic req_fire = 1'b0;

  // Work out the response of one request and update the shadow state
  function automatic bus_rsp_t bus_access(input bus_req_t r);
    bus_rsp_t o;
    logic [15:0] w;
    logic [11:0] ofs;
    logic gpr_hit;
    int gi;
    int gl;
    o = '0;
    if (r.func == FUNC_HALT) begin
      core_halted = 1'b1;
      return o;
    end
    if (r.func != FUNC_READ && r.func != FUNC_WRITE) return o;
    if ((r.addr & WIN_MASK) == WIN_MATCH) begin
      w = {6'h1f, r.addr[9:0]};
      gpr_hit = (w >= W_GPR_A_LO && w <= W_GPR_A_HI) || (w >= W_GPR_B_LO && w <= W_GPR_B_HI);
      gi = (int'(w[5:0]) / 3) % GPR_COUNT;
      gl = int'(w[5:0]) % 3;
      if (r.func == FUNC_READ) begin
        case (w)
          W_DMA_SRC0: o.rd = src_reg[7:0];
          W_DMA_SRC1: o.rd = src_reg[15:8];
          W_DMA_SRC2: o.rd = src_reg[23:16];
          W_DMA_LEN0: o.rd = len_reg[7:0];
          W_DMA_LEN1: o.rd = len_reg[15:8];
          W_DMA_TGT0: o.rd = tgt_reg[7:0];
          W_DMA_TGT1: o.rd = tgt_reg[15:8];
          W_DMA_TGT2: o.rd = tgt_reg[23:16];
          W_CTRL48:   o.rd = {7'b0, ctl_bits[0]};
          W_PRG_OFS0: o.rd = pofs_reg[7:0];
          W_PRG_OFS1: o.rd = pofs_reg[15:8];
          W_PRG_OFS2: o.rd = pofs_reg[23:16];
          W_CTRL4C:   o.rd = {6'b0, ctl_bits[2:1]};
          W_PAGE0:    o.rd = page_reg[7:0];
          W_PAGE1:    o.rd = {1'b0, page_reg[14:8]};
          W_PC:       o.rd = pc_reg;
          W_CTRL50:   o.rd = {1'b0, ctl_bits[9:3]};
          W_CTRL51:   o.rd = {7'b0, ctl_bits[10]};
          W_CTRL52:   o.rd = {7'b0, ctl_bits[11]};
          default: begin
            if (w >= W_STATUS_LO && w <= W_STATUS_HI)
              o.rd = core_halted ? STATUS_HALTED : STATUS_RUN;
            else if (w >= W_VEC_LO && w <= W_VEC_HI)
              o.rd = vec_mem[w[4:0]];
            else if (gpr_hit)
              o.rd = gpr_mem[gi][gl*8 +: 8];
          end
        endcase
      end else begin
        case (w)
          W_DMA_SRC0: src_reg[7:0] = r.data;
          W_DMA_SRC1: src_reg[15:8] = r.data;
          W_DMA_SRC2: src_reg[23:16] = r.data;
          W_DMA_LEN0: len_reg[7:0] = r.data;
          W_DMA_LEN1: len_reg[15:8] = r.data;
          W_DMA_TGT0: tgt_reg[7:0] = r.data;
          W_DMA_TGT1: tgt_reg[15:8] = r.data;
          W_DMA_TGT2: begin
            tgt_reg[23:16] = r.data;
            o.dma = core_halted;
          end
          W_CTRL48:   ctl_bits[0] = r.data[0];
          W_PRG_OFS0: pofs_reg[7:0] = r.data;
          W_PRG_OFS1: pofs_reg[15:8] = r.data;
          W_PRG_OFS2: pofs_reg[23:16] = r.data;
          W_CTRL4C:   ctl_bits[2:1] = r.data[1:0];
          W_PAGE0:    page_reg[7:0] = r.data;
          W_PAGE1:    page_reg[14:8] = r.data[6:0];
          W_PC: begin
            pc_reg = r.data;
            if (core_halted) begin
              o.core = 1'b1;
              o.pc = {page_reg, pc_reg};
              core_halted = 1'b0;
            end
          end
          W_CTRL50:   ctl_bits[9:3] = r.data[6:0] & CTRL50_MASK;
          W_CTRL51:   ctl_bits[10] = r.data[0];
          W_CTRL52:   ctl_bits[11] = r.data[0];
          default: begin
            if (w >= W_VEC_LO && w <= W_VEC_HI)
              vec_mem[w[4:0]] = r.data;
            else if (gpr_hit)
              gpr_mem[gi][gl*8 +: 8] = r.data;
          end
        endcase
      end
    end else if ((r.addr & SCRATCH_MASK) == SCRATCH_MATCH) begin
      ofs = r.addr[11:0];
      if (ofs < SCRATCH_BYTES) begin
        if (r.func == FUNC_READ) o.rd = ram_mem[ofs];
        else ram_mem[ofs] = r.data;
      end
    end else if ((r.addr & ROM_MASK) == ROM_MATCH) begin
      if (r.func == FUNC_READ) begin
        o.region = REGION_ROM;
        o.ext_addr = {r.addr[21:16], r.addr[14:0]};
      end
    end else if ((r.addr & SRAM_MASK) == SRAM_MATCH) begin
      o.region = REGION_SRAM;
      o.ext_addr = {3'b000, r.addr[18:16], r.addr[14:0]};
    end
    return o;
  endfunction

  function automatic logic [23:0] win_addr(input logic [15:0] w);
    logic [23:0] a;
    a = 24'($urandom);
    a[22] = 1'b0;
    a[15:13] = 3'b011;
    a[11:10] = 2'b11;
    a[9:0] = w[9:0];
    return a;
  endfunction

  task automatic add_req(input logic [1:0] func, input logic [23:0] addr,
                         input logic [7:0] data);
    bus_req_t r;
    r.func = func;
    r.addr = addr;
    r.data = data;
    bus_req_q.push_back(r);
    sent_total++;
  endtask

  task automatic random_traffic(input int n);
    int k;
    int pick;
    logic [15:0] w;
    logic [23:0] a;
    logic [1:0] rw;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(99);
      rw = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
      a = 24'($urandom);
      if (pick < 30) begin
        // mostly the populated top of the window, now and then anywhere in it
        if ($urandom_range(9) == 0) w = {6'h1f, 10'($urandom)};
        else w = 16'h7f40 + 16'($urandom_range(191));
        add_req(rw, win_addr(w), 8'($urandom));
        k++;
      end else if (pick < 50) begin
        a[22] = 1'b0;
        a[15:13] = 3'b011;
        // a few hot bytes so reads often find earlier writes
        a[11:0] = $urandom_range(1) ? 12'($urandom_range(15)) : 12'($urandom_range(12'hbff));
        add_req(rw, a, 8'($urandom));
        k++;
      end else if (pick < 60) begin
        a[22] = 1'b0;
        a[15] = 1'b1;
        add_req(rw, a, 8'($urandom));
        k++;
      end else if (pick < 70) begin
        a[23:19] = 5'b01110;
        a[15] = 1'b0;
        add_req(rw, a, 8'($urandom));
        k++;
      end else if (pick < 75) begin
        add_req(rw, a, 8'($urandom));
        k++;
      end else if (pick < 80) begin
        add_req(FUNC_HALT, a, 8'($urandom));
        k++;
      end else if (pick < 83) begin
        add_req(FUNC_UNUSED, a, 8'($urandom));
        k++;
      end else begin
        // start sequence: halt, page, DMA target, program counter, status
        if ($urandom_range(3) != 0) begin
          add_req(FUNC_HALT, a, 8'($urandom));
          k++;
        end
        add_req(FUNC_WRITE, win_addr(W_PAGE0), 8'($urandom));
        add_req(FUNC_WRITE, win_addr(W_PAGE1), 8'($urandom));
        add_req(FUNC_WRITE, win_addr(W_DMA_TGT2), 8'($urandom));
        add_req(FUNC_WRITE, win_addr(W_PC), 8'($urandom));
        add_req(FUNC_READ, win_addr(W_STATUS_LO + 16'($urandom_range(12))), 8'($urandom));
        k += 5;
      end
    end
  endtask

  task automatic wait_drained();
    while (taken_total != sent_total || due_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    random_traffic(n / 2);
    // pause the sender until every response is back
    wait_drained();
    random_traffic(n - n / 2);
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.func = FUNC_READ;
    req_bus.bus_address = '0;
    req_bus.write_byte = '0;
    rsp_bus.ready = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
  end

  // Request driver
  always @(negedge clk) begin : drive_req
    bus_req_t nxt;
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_fire) begin
      if (bus_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = bus_req_q.pop_front();
        req_bus.valid <= 1'b1;
        req_bus.func <= nxt.func;
        req_bus.bus_address <= nxt.addr;
        req_bus.write_byte <= nxt.data;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Response acceptor, with the long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_on && hold_cnt < HOLD_CYCLES) begin
      rsp_bus.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check responses, then predict for the request taken at this edge
  always @(posedge clk) begin : check_rsp
    bus_rsp_t got;
    bus_rsp_t want;
    cycle_count <= cycle_count + 1;
    req_fire <= !rst && req_bus.valid && req_bus.ready;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.rd = rsp_bus.read_byte;
        got.region = rsp_bus.external_region;
        got.ext_addr = rsp_bus.external_address;
        got.dma = rsp_bus.dma_start;
        got.core = rsp_bus.core_start;
        got.pc = rsp_bus.start_pc;
        if (due_rsp_q.size() == 0) begin
          if (mism_count < 10)
            $display("unexpected response: rd %h region %0d addr %h dma %b core %b pc %h",
                     got.rd, got.region, got.ext_addr, got.dma, got.core, got.pc);
          mism_count++;
        end else begin
          want = due_rsp_q.pop_front();
          if (got.rd !== want.rd || got.region !== want.region ||
              got.ext_addr !== want.ext_addr || got.dma !== want.dma ||
              got.core !== want.core || got.pc !== want.pc) begin
            if (mism_count < 10) begin
              $display("mismatch exp: rd %h region %0d addr %h dma %b core %b pc %h",
                       want.rd, want.region, want.ext_addr, want.dma, want.core, want.pc);
              $display("         got: rd %h region %0d addr %h dma %b core %b pc %h",
                       got.rd, got.region, got.ext_addr, got.dma, got.core, got.pc);
            end
            mism_count++;
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        due_rsp_q.push_back(bus_access('{req_bus.func, req_bus.bus_address,
                                         req_bus.write_byte}));
        taken_total++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb_coprocessor_bus_register_file NOT OK");
    $finish;
  end

  initial begin : stimulus
    foreach (vec_mem[i]) vec_mem[i] = '0;
    foreach (gpr_mem[i]) gpr_mem[i] = '0;
    foreach (ram_mem[i]) ram_mem[i] = '0;
    while (rst) @(posedge clk);

    // directed pass: halted status, pulses, masks, mirrors, every region
    add_req(FUNC_READ, win_addr(W_STATUS_LO), 8'h00);
    add_req(FUNC_READ, win_addr(W_STATUS_HI), 8'h00);
    add_req(FUNC_WRITE, win_addr(W_DMA_TGT2), 8'hff);
    add_req(FUNC_WRITE, win_addr(W_PAGE0), 8'hff);
    add_req(FUNC_WRITE, win_addr(W_PAGE1), 8'hff);
    add_req(FUNC_WRITE, win_addr(W_PC), 8'hff);
    add_req(FUNC_READ, win_addr(W_STATUS_LO), 8'h00);
    add_req(FUNC_WRITE, win_addr(W_PC), 8'h00);
    add_req(FUNC_WRITE, win_addr(W_DMA_TGT2), 8'h00);
    add_req(FUNC_WRITE, win_addr(W_CTRL50), 8'hff);
    add_req(FUNC_READ, win_addr(W_CTRL50), 8'h00);
    add_req(FUNC_WRITE, win_addr(W_STATUS_HI), 8'hff);
    add_req(FUNC_HALT, 24'hffffff, 8'hff);
    add_req(FUNC_UNUSED, 24'hffffff, 8'hff);
    add_req(FUNC_WRITE, win_addr(W_VEC_HI), 8'ha5);
    add_req(FUNC_READ, win_addr(W_VEC_HI), 8'h00);
    add_req(FUNC_WRITE, win_addr(W_GPR_B_HI), 8'h5a);
    add_req(FUNC_READ, win_addr(W_GPR_A_HI), 8'h00);
    add_req(FUNC_WRITE, 24'h3f7bff, 8'hc3);
    add_req(FUNC_READ, 24'h006bff, 8'h00);
    add_req(FUNC_READ, 24'hbfffff, 8'h00);
    add_req(FUNC_WRITE, 24'h00ffff, 8'h00);
    add_req(FUNC_READ, 24'h777fff, 8'h00);
    add_req(FUNC_WRITE, 24'h700000, 8'h00);
    add_req(FUNC_READ, win_addr(W_UNMAPPED), 8'h00);
    wait_drained();

    run_phase(0, 0, 250);
    run_phase(78, 0, 250);
    run_phase(0, 78, 250);
    run_phase(12, 12, 250);

    // hold off the receiver while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_on = 1'b1;
    random_traffic(40);
    while (hold_cnt < HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
    wait_drained();

    repeat (10) @(posedge clk);
    if (mism_count == 0 && due_rsp_q.size() == 0)
      $display("tb_coprocessor_bus_register_file OK");
    else
      $display("tb_coprocessor_bus_register_file NOT OK");
    $finish;
  end

endmodule
